@@ design/longest_balanced_run_finder_macros.svh @@
// ---------------------------------------------------------------------------
// longest balanced run finder assertion macros
// shared concurrent assertion wrappers, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef LONGEST_BALANCED_RUN_FINDER_MACROS_SVH
`define LONGEST_BALANCED_RUN_FINDER_MACROS_SVH

// condition must hold at every edge out of reset
`define LBRF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define LBRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lbrf_pkg.sv @@
// ---------------------------------------------------------------------------
// lbrf_pkg
// constants and types of the longest balanced run finder
// ---------------------------------------------------------------------------
`default_nettype none

package lbrf_pkg;

  localparam int MaxLen   = 1024;
  localparam int PosW     = $clog2(MaxLen + 1);
  localparam int BalW     = PosW + 1;
  localparam int TabDepth = 2 * MaxLen + 1;
  localparam int AddrW    = $clog2(TabDepth);
  localparam int StartW   = 10;
  localparam int LenW     = 11;
  localparam int CodeW    = 8;
  localparam int OutDataW = 24;
  localparam int QDepth   = 3;
  localparam int QPtrW    = 2;
  localparam int QCntW    = 2;

  localparam logic [CodeW-1:0] LetterCode = 8'd65;

  // one result word waiting for the output side
  typedef struct packed {
    logic [StartW-1:0] best_start;
    logic [LenW-1:0]   best_length;
    logic              overflow;
    logic              final_res;
  } result_t;

  // element in flight between table read and best update
  typedef struct packed {
    logic            act;
    logic            seen;
    logic            zero;
    logic [PosW-1:0] pos1;
    logic            ovf;
    logic            last;
  } stage_t;

endpackage

`default_nettype wire

@@ design/lbrf_outq.sv @@
// ---------------------------------------------------------------------------
// lbrf_outq
// three-entry result queue that decouples the pipeline from out_tready
// ---------------------------------------------------------------------------
`default_nettype none

module lbrf_outq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire lbrf_pkg::result_t          push_data,
  output logic [lbrf_pkg::QCntW-1:0]      count,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output lbrf_pkg::result_t               out_data
);
  import lbrf_pkg::*;

  result_t            q_mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r;
  logic [QPtrW-1:0]   rd_ptr_r;
  logic [QCntW-1:0]   cnt_r;
  logic               pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  assign out_data   = q_mem[rd_ptr_r];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`include "longest_balanced_run_finder_macros.svh"

  `LBRF_ASSERT_ALWAYS(a_no_push_full, !(push && !pop && cnt_r == QCntW'(QDepth)), "push into full queue")
  `LBRF_ASSERT_ALWAYS(a_cnt_range, cnt_r <= QCntW'(QDepth), "queue count out of range")
  `LBRF_ASSERT_NEXT(a_push_shows, push && cnt_r == '0, out_tvalid, "pushed word not presented")

endmodule

`default_nettype wire

@@ design/longest_balanced_run_finder.sv @@
// ---------------------------------------------------------------------------
// longest_balanced_run_finder
// finds the longest span with equal letter and digit counts in a stream
// ---------------------------------------------------------------------------
//  channel | dir | tdata bits (low first)                      | tlast
//  in_     | in  | char_code[7:0]                              | last
//  out_    | out | best_start[9:0] best_length[20:10] ovf[21]  | final_res
//
//  one element per cycle while in_tready is high, one result per element; a
//  result can be taken at the earliest after the table read in stage one,
//  then the best update into the queue
//  the first-sighting table is a 2049-entry memory, one port read and one
//  port written per cycle; within a stream, balances of neighboring counted
//  elements differ; seen marks are the balance range visited so far, so no
//  clearing pass; a stalled output fills the three-entry result queue;
//  in_tready drops once the queue and stage one together hold three words
// ---------------------------------------------------------------------------
`default_nettype none

module longest_balanced_run_finder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_code[7:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // best_start[9:0], best_length[20:10], overflow[21]
  output logic             out_tlast
);
  import lbrf_pkg::*;

  // first sighting per balance, stored as position plus one
  logic [PosW-1:0]          fsp_mem [TabDepth];
  logic [PosW-1:0]          rd_data_r;

  logic signed [BalW-1:0]   bal_r;
  logic signed [BalW-1:0]   min_r;
  logic signed [BalW-1:0]   max_r;
  logic [PosW-1:0]          pos_r;
  logic                     ovf_r;

  logic                     in_ok;
  logic                     act;
  logic signed [BalW-1:0]   bal_nxt;
  logic                     seen;
  logic [AddrW-1:0]         addr;

  logic                     s1_v_r;
  stage_t                   s1_r;

  logic [LenW-1:0]          best_len_r;
  logic [StartW-1:0]        best_start_r;
  logic [PosW-1:0]          from;
  logic [LenW-1:0]          span;
  logic                     upd;
  logic [LenW-1:0]          len_nxt;
  logic [StartW-1:0]        start_nxt;

  result_t                  res;
  result_t                  q_out;
  logic [QCntW-1:0]         q_count;

  assign in_tready = ({1'b0, q_count} + {{QCntW{1'b0}}, s1_v_r}) <= (QCntW + 1)'(QDepth - 1);
  assign in_ok     = in_tvalid & in_tready;
  assign act       = pos_r < PosW'(MaxLen);
  assign bal_nxt   = (in_tdata >= LetterCode) ? bal_r + BalW'(1) : bal_r - BalW'(1);
  // visited balances always form one contiguous range around zero
  assign seen      = (bal_nxt >= min_r) && (bal_nxt <= max_r);
  assign addr      = AddrW'(bal_nxt) + AddrW'(MaxLen);

  // table memory
  always_ff @(posedge clk) begin
    if (in_ok && act && !seen) begin
      fsp_mem[addr] <= pos_r + 1'b1;
    end
    rd_data_r <= fsp_mem[addr];
  end

  // balance, position and seen range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_r <= '0;
      min_r <= '0;
      max_r <= '0;
      pos_r <= '0;
      ovf_r <= 1'b0;
    end else if (in_ok) begin
      if (in_tlast) begin
        bal_r <= '0;
        min_r <= '0;
        max_r <= '0;
        pos_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        ovf_r <= ovf_r | ~act;
        if (act) begin
          bal_r <= bal_nxt;
          pos_r <= pos_r + 1'b1;
          if (!seen && bal_nxt < min_r) begin
            min_r <= bal_nxt;
          end
          if (!seen && bal_nxt > max_r) begin
            max_r <= bal_nxt;
          end
        end
      end
    end
  end

  // stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ok) begin
      s1_r.act  <= act;
      s1_r.seen <= seen;
      s1_r.zero <= (bal_nxt == '0);
      s1_r.pos1 <= pos_r + 1'b1;
      s1_r.ovf  <= ovf_r | ~act;
      s1_r.last <= in_tlast;
    end
  end

  // best span update
  assign from      = s1_r.zero ? '0 : rd_data_r;
  assign span      = LenW'(s1_r.pos1 - from);
  assign upd       = s1_v_r && s1_r.act && s1_r.seen && (span > best_len_r);
  assign len_nxt   = upd ? span : best_len_r;
  assign start_nxt = upd ? from[StartW-1:0] : best_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_len_r   <= '0;
      best_start_r <= '0;
    end else if (s1_v_r) begin
      if (s1_r.last) begin
        best_len_r   <= '0;
        best_start_r <= '0;
      end else begin
        best_len_r   <= len_nxt;
        best_start_r <= start_nxt;
      end
    end
  end

  assign res.best_start  = start_nxt;
  assign res.best_length = len_nxt;
  assign res.overflow    = s1_r.ovf;
  assign res.final_res   = s1_r.last;

  lbrf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_v_r),
    .push_data  (res),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (q_out)
  );

  assign out_tdata = {2'b00, q_out.overflow, q_out.best_length, q_out.best_start};
  assign out_tlast = q_out.final_res;

`include "longest_balanced_run_finder_macros.svh"

  `LBRF_ASSERT_ALWAYS(a_bal_in_range, bal_r >= min_r && bal_r <= max_r, "balance outside seen range")
  `LBRF_ASSERT_ALWAYS(a_range_holds_zero, min_r <= 0 && max_r >= 0, "seen range lost zero")
  `LBRF_ASSERT_ALWAYS(a_pos_limit, pos_r <= PosW'(MaxLen), "position past limit")
  `LBRF_ASSERT_NEXT(a_last_clears, s1_v_r && s1_r.last, best_len_r == '0 && best_start_r == '0, "best not cleared after last word")

endmodule

`default_nettype wire
